// ===== src/ttm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the timer table manager: opcode, result kind and controller
// state encodings, and the structs passed between the controller and the cells.

package ttm_pkg;

    // Slots reachable through the 4-bit timer_id field
    localparam int unsigned ID_SPACE = 16;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_MODIFY = 3'd2,
        OP_STOP   = 3'd3,
        OP_QUERY  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Command broadcast to every cell
    typedef struct packed {
        logic        fire;
        t_opcode     op;
        logic [3:0]  id;
        logic [30:0] dur;
        logic        rep;
    } t_cmd;

    // Status returned by each cell; query fields are zero unless addressed
    typedef struct packed {
        logic        hit;
        logic        run_sel;
        logic [30:0] rem_sel;
    } t_cell_st;

endpackage

// ===== src/ttm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the timer table manager.
// Command channel in, result channel out; no package dependency.

interface ttm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  timer_id;
    logic [30:0] duration;
    logic        repeat_mode;

    modport source (output valid, opcode, timer_id, duration, repeat_mode, input ready);
    modport sink   (input valid, opcode, timer_id, duration, repeat_mode, output ready);
endinterface

interface ttm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        status;
    logic        pending;
    logic [30:0] remaining;
    logic        last;

    modport source (output valid, kind, slot, status, pending, remaining, last, input ready);
    modport sink   (input valid, kind, slot, status, pending, remaining, last, output ready);
endinterface

// ===== src/timer_table_manager_core.sv =====
`timescale 1ns / 1ps
// Timer table manager top level: controller, tick counter, result register
// and the chain of slot cells. Depends on ttm_pkg, ttm_if and ttm_cell.
//
// Usage:
//   i_cmd carries commands (tick, start, modify, stop, query); o_res carries
//   results. Both are valid/ready channels; a transfer happens when valid and
//   ready are high at a rising edge of i_clk.
//   start, modify, stop and query each return one reply, registered, in the
//   cycle after the transfer. Opcodes 5 to 7 are taken and return nothing.
//   A tick advances the tick count, then passes a scan token down the chain
//   of NUM_TIMERS cells, one cell per cycle while o_res is not stalled, and
//   finishes with a done result marked last. Expiry events appear in
//   ascending slot order.
//   No command is taken while a tick scan runs.
//   When o_res is stalled the result register holds, the token stops and
//   i_cmd.ready drops until the register can be refilled.
//   i_rst_n (synchronous, active low) clears the tick count, all running and
//   repeat bits and the output valid bit; no clearing pass is needed.

module timer_table_manager_core #(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttm_cmd_if.sink   i_cmd,
    ttm_res_if.source o_res
);

    localparam int unsigned CW = $clog2(NUM_TIMERS);

    ttm_pkg::t_state r_state;
    ttm_pkg::t_state n_state;

    logic [31:0]   r_now;
    logic [CW-1:0] r_scan;

    logic              r_ov;
    ttm_pkg::t_kind    r_kind;
    logic [3:0]        r_slot;
    logic              r_status;
    logic              r_pending;
    logic [30:0]       r_rem;
    logic              r_last;

    ttm_pkg::t_cmd     w_cmd;
    ttm_pkg::t_cell_st w_st  [NUM_TIMERS];
    logic              w_tok [NUM_TIMERS];

    logic        w_out_free;
    logic        w_fire;
    logic        w_tick;
    logic        w_adv;
    logic        w_shift;
    logic        w_hit_any;
    logic        w_run_any;
    logic [30:0] w_rem_any;
    logic        w_load_reply;
    logic        w_load_event;
    logic        w_load_done;

    assign w_out_free  = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == ttm_pkg::ST_IDLE) && w_out_free;
    assign w_fire      = i_cmd.valid && i_cmd.ready;

    assign w_cmd.fire = w_fire;
    assign w_cmd.op   = ttm_pkg::t_opcode'(i_cmd.opcode);
    assign w_cmd.id   = i_cmd.timer_id;
    assign w_cmd.dur  = i_cmd.duration;
    assign w_cmd.rep  = i_cmd.repeat_mode;

    assign w_tick  = w_fire && (w_cmd.op == ttm_pkg::OP_TICK);
    assign w_adv   = (r_state == ttm_pkg::ST_SCAN) && w_out_free;
    assign w_shift = w_adv || w_tick;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
            logic w_tin;
            if (g == 0) begin : g_head
                assign w_tin = w_tick;
            end else begin : g_link
                assign w_tin = w_tok[g-1];
            end
            ttm_cell #(
                .CELL_ID (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_now   (r_now),
                .i_shift (w_shift),
                .i_token (w_tin),
                .i_adv   (w_adv),
                .o_token (w_tok[g]),
                .o_st    (w_st[g])
            );
        end
    endgenerate

    // Only the token holder can hit and only the addressed cell drives query data
    always_comb begin
        w_hit_any = 1'b0;
        w_run_any = 1'b0;
        w_rem_any = '0;
        for (int s = 0; s < NUM_TIMERS; s++) begin
            w_hit_any = w_hit_any | w_st[s].hit;
            w_run_any = w_run_any | w_st[s].run_sel;
            w_rem_any = w_rem_any | w_st[s].rem_sel;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttm_pkg::ST_IDLE: begin
                if (w_tick) begin
                    n_state = ttm_pkg::ST_SCAN;
                end
            end
            ttm_pkg::ST_SCAN: begin
                if (w_adv && (r_scan == CW'(NUM_TIMERS - 1))) begin
                    n_state = ttm_pkg::ST_DONE;
                end
            end
            ttm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ttm_pkg::ST_IDLE;
                end
            end
            default: n_state = ttm_pkg::ST_IDLE;
        endcase
    end

    // Output loads
    always_comb begin
        w_load_reply = 1'b0;
        w_load_event = 1'b0;
        w_load_done  = 1'b0;
        unique case (r_state)
            ttm_pkg::ST_IDLE: begin
                if (w_fire) begin
                    unique case (w_cmd.op)
                        ttm_pkg::OP_START,
                        ttm_pkg::OP_MODIFY,
                        ttm_pkg::OP_STOP,
                        ttm_pkg::OP_QUERY: w_load_reply = 1'b1;
                        default:           w_load_reply = 1'b0;
                    endcase
                end
            end
            ttm_pkg::ST_SCAN: w_load_event = w_adv && w_hit_any;
            ttm_pkg::ST_DONE: w_load_done  = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttm_pkg::ST_IDLE;
            r_now   <= 32'd0;
            r_scan  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_tick) begin
                r_now  <= r_now + 32'd1;
                r_scan <= '0;
            end else if (w_adv) begin
                r_scan <= r_scan + CW'(1);
            end
            if (w_load_reply || w_load_event || w_load_done) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load_reply) begin
            r_kind    <= ttm_pkg::KIND_REPLY;
            r_slot    <= w_cmd.id;
            r_status  <= (w_cmd.op == ttm_pkg::OP_MODIFY) && w_run_any;
            r_pending <= (w_cmd.op == ttm_pkg::OP_QUERY) && w_run_any;
            r_rem     <= (w_cmd.op == ttm_pkg::OP_QUERY) ? w_rem_any : 31'd0;
            r_last    <= 1'b1;
        end else if (w_load_event) begin
            r_kind    <= ttm_pkg::KIND_EVENT;
            r_slot    <= 4'(r_scan);
            r_status  <= 1'b0;
            r_pending <= 1'b0;
            r_rem     <= 31'd0;
            r_last    <= 1'b0;
        end else if (w_load_done) begin
            r_kind    <= ttm_pkg::KIND_DONE;
            r_slot    <= 4'd0;
            r_status  <= 1'b0;
            r_pending <= 1'b0;
            r_rem     <= 31'd0;
            r_last    <= 1'b1;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.kind      = r_kind;
    assign o_res.slot      = r_slot;
    assign o_res.status    = r_status;
    assign o_res.pending   = r_pending;
    assign o_res.remaining = r_rem;
    assign o_res.last      = r_last;

endmodule

// ===== src/ttm_cell.sv =====
`timescale 1ns / 1ps
// One timer slot: expiry, period, running and repeat bits, plus the scan token.
// Depends on ttm_pkg.

module ttm_cell #(
    parameter int unsigned CELL_ID = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttm_pkg::t_cmd     i_cmd,
    input  logic [31:0]       i_now,
    input  logic              i_shift,
    input  logic              i_token,
    input  logic              i_adv,
    output logic              o_token,
    output ttm_pkg::t_cell_st o_st
);

    localparam bit ADDRESSABLE = (CELL_ID < ttm_pkg::ID_SPACE);

    logic        r_token;
    logic        r_run;
    logic        r_rep;
    logic [31:0] r_exp;
    logic [30:0] r_period;

    logic [31:0] w_diff;
    logic        w_le0;
    logic        w_hit;
    logic        w_sel;
    logic        w_fire_hit;
    logic        w_arm;

    assign w_diff = r_exp - i_now;
    assign w_le0  = (w_diff == 32'd0) || w_diff[31];
    assign w_hit  = r_token && r_run && w_le0;
    assign w_sel  = ADDRESSABLE && i_cmd.fire && (i_cmd.id == 4'(CELL_ID));
    assign w_fire_hit = i_adv && w_hit;
    // start always arms; modify arms only a stopped slot
    assign w_arm = w_sel && ((i_cmd.op == ttm_pkg::OP_START)
                          || ((i_cmd.op == ttm_pkg::OP_MODIFY) && !r_run));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
            r_run   <= 1'b0;
            r_rep   <= 1'b0;
        end else begin
            if (i_shift) begin
                r_token <= i_token;
            end
            if (w_fire_hit) begin
                r_run <= r_rep;
            end else if (w_arm) begin
                r_run <= 1'b1;
            end else if (w_sel && (i_cmd.op == ttm_pkg::OP_STOP)) begin
                r_run <= 1'b0;
            end
            if (w_sel && (i_cmd.op == ttm_pkg::OP_START)) begin
                r_rep <= i_cmd.rep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_hit && r_rep) begin
            r_exp <= i_now + {1'b0, r_period};
        end else if (w_arm) begin
            r_period <= i_cmd.dur;
            r_exp    <= i_now + {1'b0, i_cmd.dur};
        end
    end

    assign o_token       = r_token;
    assign o_st.hit      = w_hit;
    assign o_st.run_sel  = w_sel && r_run;
    assign o_st.rem_sel  = (w_sel && r_run && !w_le0) ? w_diff[30:0] : 31'd0;

endmodule

// ===== bench/tb_timer_table_manager_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timer_table_manager_core: queued commands, a slot-table
// predictor of replies, expiry events and tick-done items, and an in-order checker.
// Depends on ttm_pkg, the ttm_cmd_if/ttm_res_if channels and the core RTL.

module tb_timer_table_manager_core;

    localparam int unsigned TABLE_SIZE     = ttm_pkg::ID_SPACE;
    localparam int          RANDOM_ITEMS   = 210;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          LONG_HOLD      = 80;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [2:0]  OP_RESERVED_LO = 3'd5;
    localparam logic [2:0]  OP_RESERVED_HI = 3'd7;
    localparam logic [30:0] DUR_MAX        = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  timer_id;
        logic [30:0] duration;
        logic        repeat_mode;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        status;
        logic        pending;
        logic [30:0] remaining;
        logic        last;
    } t_timer_result;

    logic clk;
    logic rst_n;

    ttm_cmd_if cmd_ch ();
    ttm_res_if res_ch ();

    timer_table_manager_core #(
        .NUM_TIMERS(TABLE_SIZE)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Predicted slot table
    logic [31:0] tick_count;
    logic [31:0] slot_deadline [TABLE_SIZE];
    logic [30:0] slot_interval [TABLE_SIZE];
    logic        slot_armed    [TABLE_SIZE];
    logic        slot_periodic [TABLE_SIZE];

    t_cmd_item     cmd_backlog[$];
    t_timer_result outstanding_results[$];

    int   items_queued;
    int   items_taken;
    int   mismatches;
    int   quiet_cycles;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_left;
    logic hold_req;
    logic hold_ack;
    logic cmd_taken;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Signed 32-bit test: deadline - now <= 0
    function automatic logic reached(input logic [31:0] deadline);
        logic [31:0] gap;
        gap = deadline - tick_count;
        return (gap == '0) || gap[31];
    endfunction

    task automatic post_result(input logic [1:0] kind, input logic [3:0] slot,
                               input logic status, input logic pending,
                               input logic [30:0] remaining, input logic last);
        outstanding_results.push_back({kind, slot, status, pending, remaining, last});
    endtask

    task automatic arm_slot(input logic [3:0] id, input logic [30:0] dur);
        slot_interval[id] = dur;
        slot_deadline[id] = tick_count + dur;
        slot_armed[id]    = 1'b1;
    endtask

    task automatic apply_timer_command(input t_cmd_item c);
        int          i;
        logic        status;
        logic        pending;
        logic [30:0] remaining;
        status    = 1'b0;
        pending   = 1'b0;
        remaining = '0;
        if (c.opcode == ttm_pkg::OP_TICK) begin
            tick_count = tick_count + 1;
            // Ascending slot order; each slot fires at most once per tick
            for (i = 0; i < TABLE_SIZE; i++) begin
                if (slot_armed[i] && reached(slot_deadline[i])) begin
                    slot_armed[i] = 1'b0;
                    post_result(ttm_pkg::KIND_EVENT, 4'(i), 1'b0, 1'b0, '0, 1'b0);
                    if (slot_periodic[i]) begin
                        slot_deadline[i] = tick_count + slot_interval[i];
                        slot_armed[i]    = 1'b1;
                    end
                end
            end
            post_result(ttm_pkg::KIND_DONE, '0, 1'b0, 1'b0, '0, 1'b1);
        end else if (c.opcode <= ttm_pkg::OP_QUERY) begin
            if (c.timer_id < TABLE_SIZE) begin
                case (c.opcode)
                    ttm_pkg::OP_START: begin
                        slot_periodic[c.timer_id] = c.repeat_mode;
                        arm_slot(c.timer_id, c.duration);
                    end
                    ttm_pkg::OP_MODIFY: begin
                        if (slot_armed[c.timer_id]) status = 1'b1;
                        else arm_slot(c.timer_id, c.duration);
                    end
                    ttm_pkg::OP_STOP: begin
                        slot_armed[c.timer_id] = 1'b0;
                    end
                    default: begin
                        if (slot_armed[c.timer_id]) begin
                            pending = 1'b1;
                            if (!reached(slot_deadline[c.timer_id]))
                                remaining = 31'(slot_deadline[c.timer_id] - tick_count);
                        end
                    end
                endcase
            end
            post_result(ttm_pkg::KIND_REPLY, c.timer_id, status, pending, remaining, 1'b1);
        end
    endtask

    task automatic push_cmd(input logic [2:0] op, input logic [3:0] id,
                            input logic [30:0] dur, input logic rep);
        cmd_backlog.push_back({op, id, dur, rep});
        items_queued++;
    endtask

    function automatic logic [30:0] pick_duration();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 31'($urandom_range(6));
        if (r < 80) return 31'($urandom_range(40));
        if (r < 95) return 31'($urandom);
        return r[0] ? DUR_MAX : 31'd0;
    endfunction

    task automatic queue_random(input int n);
        int          made;
        int unsigned pick;
        t_cmd_item   c;
        made = 0;
        while (made < n) begin
            pick          = $urandom_range(99);
            // Favour a few slots so commands and ticks interact
            c.timer_id    = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            c.duration    = pick_duration();
            c.repeat_mode = 1'($urandom_range(1));
            if (pick < 22)      c.opcode = ttm_pkg::OP_TICK;
            else if (pick < 50) c.opcode = ttm_pkg::OP_START;
            else if (pick < 62) c.opcode = ttm_pkg::OP_MODIFY;
            else if (pick < 74) c.opcode = ttm_pkg::OP_STOP;
            else if (pick < 94) c.opcode = ttm_pkg::OP_QUERY;
            else c.opcode = 3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
            if (c.opcode <= ttm_pkg::OP_QUERY) made++;
            push_cmd(c.opcode, c.timer_id, c.duration, c.repeat_mode);
        end
    endtask

    task automatic queue_directed();
        push_cmd(ttm_pkg::OP_QUERY,  4'd0,  31'd0,   1'b0);  // never armed
        push_cmd(ttm_pkg::OP_TICK,   4'd0,  31'd0,   1'b0);  // nothing due
        push_cmd(ttm_pkg::OP_START,  4'd0,  31'd0,   1'b0);  // zero duration
        push_cmd(ttm_pkg::OP_START,  4'd15, DUR_MAX, 1'b1);
        push_cmd(ttm_pkg::OP_QUERY,  4'd15, 31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_START,  4'd3,  31'd0,   1'b1);  // zero period, repeating
        push_cmd(ttm_pkg::OP_MODIFY, 4'd3,  31'd5,   1'b0);  // running: rejected
        push_cmd(ttm_pkg::OP_TICK,   4'd0,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_QUERY,  4'd3,  31'd0,   1'b0);  // due at this tick
        push_cmd(ttm_pkg::OP_TICK,   4'd0,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_STOP,   4'd3,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_STOP,   4'd3,  31'd0,   1'b0);  // already stopped
        push_cmd(ttm_pkg::OP_MODIFY, 4'd3,  31'd2,   1'b0);  // stopped: keeps repeat bit
        push_cmd(ttm_pkg::OP_QUERY,  4'd0,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_START,  4'd7,  31'd1,   1'b0);
        push_cmd(ttm_pkg::OP_START,  4'd7,  31'd3,   1'b1);  // restart while running
        push_cmd(ttm_pkg::OP_TICK,   4'd0,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_TICK,   4'd0,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_TICK,   4'd0,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_QUERY,  4'd7,  31'd0,   1'b0);
        push_cmd(ttm_pkg::OP_STOP,   4'd15, DUR_MAX, 1'b1);
        push_cmd(OP_RESERVED_LO,         4'd1, 31'd4, 1'b1);
        push_cmd(OP_RESERVED_LO + 3'd1,  4'd2, 31'd5, 1'b0);
        push_cmd(OP_RESERVED_HI,         4'd3, 31'd6, 1'b1);
    endtask

    // Arm every slot to expire together so one tick yields its largest burst
    task automatic queue_flood();
        int i;
        for (i = 0; i < TABLE_SIZE; i++)
            push_cmd(ttm_pkg::OP_START, 4'(i), 31'd0, 1'($urandom_range(1)));
        push_cmd(ttm_pkg::OP_TICK, 4'd0, 31'd0, 1'b0);
        push_cmd(ttm_pkg::OP_TICK, 4'd0, 31'd0, 1'b0);
    endtask

    // Hold the sender until every queued command is taken and all results are in
    task automatic settle();
        wait (items_taken == items_queued);
        while (outstanding_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Check results and record command transfers
    always @(posedge clk) begin
        t_timer_result got;
        t_timer_result want;
        if (!rst_n) begin
            cmd_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.kind, res_ch.slot, res_ch.status, res_ch.pending,
                       res_ch.remaining, res_ch.last};
                if (outstanding_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"unexpected result: kind %0d slot %0d status %0d",
                                  " pending %0d remaining %0d last %0d"},
                                 got.kind, got.slot, got.status, got.pending,
                                 got.remaining, got.last);
                end else begin
                    want = outstanding_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result mismatch at %0t: expected kind %0d slot %0d",
                                      " status %0d pending %0d remaining %0d last %0d,",
                                      " got kind %0d slot %0d status %0d pending %0d",
                                      " remaining %0d last %0d"},
                                     $realtime, want.kind, want.slot, want.status,
                                     want.pending, want.remaining, want.last,
                                     got.kind, got.slot, got.status, got.pending,
                                     got.remaining, got.last);
                    end
                end
            end
            // Predict after checking so a same-edge result never meets its own expectation
            if (cmd_ch.valid && cmd_ch.ready) begin
                items_taken++;
                apply_timer_command({cmd_ch.opcode, cmd_ch.timer_id, cmd_ch.duration,
                                     cmd_ch.repeat_mode});
            end
            cmd_taken    <= cmd_ch.valid && cmd_ch.ready;
            quiet_cycles <= ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                            ? 0 : quiet_cycles + 1;
        end
    end

    // Command driver: advance to the next queued command once a transfer has happened
    always @(negedge clk) begin
        t_cmd_item nxt;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = cmd_backlog.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.opcode      <= nxt.opcode;
                cmd_ch.timer_id    <= nxt.timer_id;
                cmd_ch.duration    <= nxt.duration;
                cmd_ch.repeat_mode <= nxt.repeat_mode;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold on request
    always @(negedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_req && !hold_ack) begin
            hold_ack     <= 1'b1;
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("timer_table_manager_core regression: fail");
        $finish;
    end

    initial begin
        int i;
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = '0;
        cmd_ch.timer_id    = '0;
        cmd_ch.duration    = '0;
        cmd_ch.repeat_mode = 1'b0;
        res_ch.ready       = 1'b0;
        hold_req           = 1'b0;
        hold_ack           = 1'b0;
        hold_left          = 0;
        cmd_taken          = 1'b0;
        quiet_cycles       = 0;
        items_queued       = 0;
        items_taken        = 0;
        mismatches         = 0;
        tick_count         = '0;
        for (i = 0; i < TABLE_SIZE; i++) begin
            slot_deadline[i] = '0;
            slot_interval[i] = '0;
            slot_armed[i]    = 1'b0;
            slot_periodic[i] = 1'b0;
        end
        src_idle_pct = 16;
        snk_idle_pct = 66;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        queue_random(RANDOM_ITEMS / 3);
        settle();

        src_idle_pct = 66;
        snk_idle_pct = 16;
        queue_random(RANDOM_ITEMS / 3);
        settle();

        // Stall the receiver while the sender keeps offering a full burst
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        queue_flood();
        queue_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("timer_table_manager_core regression: pass");
        end else begin
            $display("timer_table_manager_core regression: fail");
        end
        $finish;
    end

endmodule
